// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ccfp: implication failed");

// Delayed implication: the consequent is checked after the delay given by n.
`define CCFP_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("ccfp: delayed implication failed");

`endif

// ----- src/ccfp_pkg.sv -----
package ccfp_pkg;

	localparam int CCFP_COORD_WIDTH = 32;
	localparam int CCFP_THR_WIDTH   = 32;
	localparam logic [CCFP_THR_WIDTH-1:0] CCFP_THR_RESET = 32'd1;

	// quotient bits kept by the divider
	function automatic int ccfp_qbits(input int w);
		return w + 3;
	endfunction

	// numerator magnitude width
	function automatic int ccfp_num_w(input int w);
		return 3 * w + 1;
	endfunction

	// divisor (2*|det|) width
	function automatic int ccfp_den_w(input int w);
		return 2 * w + 3;
	endfunction

	// start to done, in cycles
	function automatic int ccfp_latency(input int w);
		return 2 * w + 15;
	endfunction

	typedef struct packed {
		logic collinear;
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
	} ccfp_ctl_t;

endpackage

// ----- src/ccfp_front.sv -----
module ccfp_front #(
	parameter int COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [COORD_WIDTH-1:0]         first_x,
	input  logic signed [COORD_WIDTH-1:0]         first_y,
	input  logic signed [COORD_WIDTH-1:0]         second_x,
	input  logic signed [COORD_WIDTH-1:0]         second_y,
	input  logic signed [COORD_WIDTH-1:0]         third_x,
	input  logic signed [COORD_WIDTH-1:0]         third_y,
	input  logic [ccfp_pkg::CCFP_THR_WIDTH-1:0]   threshold,
	output logic                                  out_valid,
	output ccfp_pkg::ccfp_ctl_t                   out_ctl,
	output logic signed [COORD_WIDTH-1:0]         out_x1,
	output logic signed [COORD_WIDTH-1:0]         out_y1,
	output logic [ccfp_pkg::ccfp_num_w(COORD_WIDTH)-1:0] out_numx,
	output logic [ccfp_pkg::ccfp_num_w(COORD_WIDTH)-1:0] out_numy,
	output logic [ccfp_pkg::ccfp_den_w(COORD_WIDTH)-1:0] out_den
);
	import ccfp_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int AW  = W + 1;
	localparam int QW  = 2 * W - 1;
	localparam int SW  = 2 * W;
	localparam int EW  = 2 * W + 1;
	localparam int PW  = 2 * W + 2;
	localparam int DW  = ccfp_den_w(W);
	localparam int NSW = 3 * W + 3;
	localparam int NAW = ccfp_num_w(W);
	localparam int K   = ccfp_qbits(W);

	// stage 1
	logic v_s1;
	logic signed [AW-1:0] a_s1, b_s1, c_s1, d_s1;
	logic [QW-1:0] sqx1_s1, sqy1_s1, sqx2_s1, sqy2_s1, sqx3_s1, sqy3_s1;
	logic signed [W-1:0] x1_s1, y1_s1;
	// stage 2
	logic v_s2;
	logic signed [AW-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [EW-1:0] e_s2, f_s2;
	logic signed [PW-1:0] ad_s2, bc_s2;
	logic signed [W-1:0] x1_s2, y1_s2;
	// stage 3
	logic v_s3;
	logic signed [DW-1:0] den_s3;
	logic signed [PW-1:0] edl_s3, edh_s3, bfl_s3, bfh_s3, afl_s3, afh_s3, ecl_s3, ech_s3;
	logic signed [W-1:0] x1_s3, y1_s3;
	// stage 4
	logic v_s4;
	logic signed [NSW-1:0] nx_s4, ny_s4;
	logic [DW-1:0] d2_s4;
	logic dneg_s4, col_s4;
	logic signed [W-1:0] x1_s4, y1_s4;
	// stage 5
	logic v_s5;
	ccfp_ctl_t ctl_s5;
	logic [NAW-1:0] anx_s5, any_s5;
	logic [DW-1:0] d2_s5;
	logic signed [W-1:0] x1_s5, y1_s5;

	logic signed [SW-1:0] px1, py1, px2, py2, px3, py3;
	logic [SW-1:0] s1, s2, s3;
	logic signed [AW-1:0] el, eh, fl, fh;
	logic signed [NSW-1:0] ed, bf, af, ec;
	logic [DW-1:0] aden;
	logic signed [NSW-1:0] anx_w, any_w;
	logic [DW-1:0] remx0, remy0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		px1 = first_x * first_x;
		py1 = first_y * first_y;
		px2 = second_x * second_x;
		py2 = second_y * second_y;
		px3 = third_x * third_x;
		py3 = third_y * third_y;
	end

	always_ff @(posedge clk) begin
		a_s1    <= AW'(first_x) - AW'(second_x);
		b_s1    <= AW'(first_y) - AW'(second_y);
		c_s1    <= AW'(first_x) - AW'(third_x);
		d_s1    <= AW'(first_y) - AW'(third_y);
		sqx1_s1 <= px1[QW-1:0];
		sqy1_s1 <= py1[QW-1:0];
		sqx2_s1 <= px2[QW-1:0];
		sqy2_s1 <= py2[QW-1:0];
		sqx3_s1 <= px3[QW-1:0];
		sqy3_s1 <= py3[QW-1:0];
		x1_s1   <= first_x;
		y1_s1   <= first_y;
	end

	always_comb begin
		s1 = SW'(sqx1_s1) + SW'(sqy1_s1);
		s2 = SW'(sqx2_s1) + SW'(sqy2_s1);
		s3 = SW'(sqx3_s1) + SW'(sqy3_s1);
	end

	always_ff @(posedge clk) begin
		e_s2  <= $signed({1'b0, s1}) - $signed({1'b0, s2});
		f_s2  <= $signed({1'b0, s1}) - $signed({1'b0, s3});
		ad_s2 <= a_s1 * d_s1;
		bc_s2 <= b_s1 * c_s1;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		c_s2  <= c_s1;
		d_s2  <= d_s1;
		x1_s2 <= x1_s1;
		y1_s2 <= y1_s1;
	end

	// split E and F into a low unsigned and a high signed half
	always_comb begin
		el = $signed({1'b0, e_s2[W-1:0]});
		eh = $signed(e_s2[EW-1:W]);
		fl = $signed({1'b0, f_s2[W-1:0]});
		fh = $signed(f_s2[EW-1:W]);
	end

	always_ff @(posedge clk) begin
		den_s3 <= DW'(ad_s2) - DW'(bc_s2);
		edl_s3 <= el * d_s2;
		edh_s3 <= eh * d_s2;
		bfl_s3 <= b_s2 * fl;
		bfh_s3 <= b_s2 * fh;
		afl_s3 <= a_s2 * fl;
		afh_s3 <= a_s2 * fh;
		ecl_s3 <= el * c_s2;
		ech_s3 <= eh * c_s2;
		x1_s3  <= x1_s2;
		y1_s3  <= y1_s2;
	end

	always_comb begin
		ed   = (NSW'(edh_s3) <<< W) + NSW'(edl_s3);
		bf   = (NSW'(bfh_s3) <<< W) + NSW'(bfl_s3);
		af   = (NSW'(afh_s3) <<< W) + NSW'(afl_s3);
		ec   = (NSW'(ech_s3) <<< W) + NSW'(ecl_s3);
		aden = den_s3[DW-1] ? DW'(-den_s3) : DW'(den_s3);
	end

	always_ff @(posedge clk) begin
		nx_s4   <= ed - bf;
		ny_s4   <= af - ec;
		d2_s4   <= {aden[DW-2:0], 1'b0};
		dneg_s4 <= den_s3[DW-1];
		col_s4  <= (aden == '0) || (aden < DW'(threshold));
		x1_s4   <= x1_s3;
		y1_s4   <= y1_s3;
	end

	always_comb begin
		anx_w = nx_s4[NSW-1] ? -nx_s4 : nx_s4;
		any_w = ny_s4[NSW-1] ? -ny_s4 : ny_s4;
		remx0 = DW'(anx_w[NAW-1:K]);
		remy0 = DW'(any_w[NAW-1:K]);
	end

	always_ff @(posedge clk) begin
		anx_s5           <= anx_w[NAW-1:0];
		any_s5           <= any_w[NAW-1:0];
		d2_s5            <= d2_s4;
		ctl_s5.collinear <= col_s4;
		ctl_s5.negx      <= nx_s4[NSW-1] ^ dneg_s4;
		ctl_s5.negy      <= ny_s4[NSW-1] ^ dneg_s4;
		ctl_s5.ovfx      <= remx0 >= d2_s4;
		ctl_s5.ovfy      <= remy0 >= d2_s4;
		x1_s5            <= x1_s4;
		y1_s5            <= y1_s4;
	end

	assign out_valid = v_s5;
	assign out_ctl   = ctl_s5;
	assign out_x1    = x1_s5;
	assign out_y1    = y1_s5;
	assign out_numx  = anx_s5;
	assign out_numy  = any_s5;
	assign out_den   = d2_s5;

endmodule

// ----- src/ccfp_rdiv.sv -----
module ccfp_rdiv #(
	parameter int COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH,
	parameter int SB_W        = 1
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	input  logic [ccfp_pkg::ccfp_num_w(COORD_WIDTH)-1:0]  in_num,
	input  logic [ccfp_pkg::ccfp_den_w(COORD_WIDTH)-1:0]  in_den,
	input  logic                                          in_neg,
	input  logic                                          in_ovf,
	input  logic [SB_W-1:0]                               in_sb,
	output logic                                          out_valid,
	output logic signed [COORD_WIDTH+2:0]                 out_quot,
	output logic [SB_W-1:0]                               out_sb
);
	import ccfp_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int K   = ccfp_qbits(W);
	localparam int NAW = ccfp_num_w(W);
	localparam int DW  = ccfp_den_w(W);
	localparam int MW  = W + 2;

	logic            v_s   [0:K];
	logic [DW-1:0]   rem_s [0:K];
	logic [DW-1:0]   den_s [0:K];
	logic [K-1:0]    q_s   [0:K];
	logic [K-1:0]    lo_s  [0:K];
	logic            neg_s [0:K];
	logic            ovf_s [0:K];
	logic [SB_W-1:0] sb_s  [0:K];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = DW'(in_num[NAW-1:K]);
	assign den_s[0] = in_den;
	assign q_s[0]   = '0;
	assign lo_s[0]  = in_num[K-1:0];
	assign neg_s[0] = in_neg;
	assign ovf_s[0] = in_ovf;
	assign sb_s[0]  = in_sb;

	for (genvar i = 1; i <= K; i++) begin : g_stage
		logic [DW:0] cur;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			cur  = {rem_s[i-1], lo_s[i-1][K-1]};
			diff = cur - {1'b0, den_s[i-1]};
			ge   = cur >= {1'b0, den_s[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[DW-1:0] : cur[DW-1:0];
			q_s[i]   <= {q_s[i-1][K-2:0], ge};
			lo_s[i]  <= lo_s[i-1] << 1;
			den_s[i] <= den_s[i-1];
			neg_s[i] <= neg_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
			sb_s[i]  <= sb_s[i-1];
		end
	end

	// round half away from zero, clamp far out-of-range magnitudes
	localparam logic [K:0] CLAMP = (K+1)'(1) << (W + 1);

	logic [K:0]    qr;
	logic [MW-1:0] mag;
	logic          rnd;

	always_comb begin
		rnd = {rem_s[K], 1'b0} >= {1'b0, den_s[K]};
		qr  = {1'b0, q_s[K]} + (K+1)'(rnd);
		mag = (ovf_s[K] || qr > CLAMP) ? CLAMP[MW-1:0] : qr[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[K];
		end
	end

	always_ff @(posedge clk) begin
		out_quot <= neg_s[K] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		out_sb   <= sb_s[K];
	end

endmodule

// ----- src/ccfp_isqrt.sv -----
module ccfp_isqrt #(
	parameter int COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH,
	parameter int SB_W        = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [2*COORD_WIDTH+3:0]   in_rad,
	input  logic [SB_W-1:0]            in_sb,
	output logic                       out_valid,
	output logic [COORD_WIDTH+1:0]     out_root,
	output logic [SB_W-1:0]            out_sb
);
	localparam int RK   = COORD_WIDTH + 2;
	localparam int RW   = 2 * RK;
	localparam int REMW = RK + 3;

	logic            v_s    [0:RK];
	logic [REMW-1:0] rem_s  [0:RK];
	logic [RK-1:0]   root_s [0:RK];
	logic [RW-1:0]   rad_s  [0:RK];
	logic [SB_W-1:0] sb_s   [0:RK];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign sb_s[0]   = in_sb;

	for (genvar i = 1; i <= RK; i++) begin : g_stage
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;
		logic            ge;

		always_comb begin
			cur   = {rem_s[i-1][REMW-3:0], rad_s[i-1][RW-1:RW-2]};
			trial = REMW'({root_s[i-1], 2'b01});
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? cur - trial : cur;
			root_s[i] <= {root_s[i-1][RK-2:0], ge};
			rad_s[i]  <= rad_s[i-1] << 2;
			sb_s[i]   <= sb_s[i-1];
		end
	end

	assign out_valid = v_s[RK];
	assign out_root  = root_s[RK];
	assign out_sb    = sb_s[RK];

endmodule

// ----- src/circumcircle_from_three_points_core.sv -----
// Circumcircle of three points in signed fixed point. A transaction is taken on
// every cycle that start is high; busy is always low. Each result appears on
// the output ports for exactly one cycle, flagged by done. The pipeline is made
// of the rounding divider (one quotient bit per stage, rounded at the output)
// and the integer square root (COORD_WIDTH+2 stages, one root bit per stage),
// around five front stages and four back stages. The receiver must take every
// result when done is high. collinear_threshold is at byte address 0.
module circumcircle_from_three_points_core #(
	parameter int COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       first_x,
	input  logic signed [COORD_WIDTH-1:0]       first_y,
	input  logic signed [COORD_WIDTH-1:0]       second_x,
	input  logic signed [COORD_WIDTH-1:0]       second_y,
	input  logic signed [COORD_WIDTH-1:0]       third_x,
	input  logic signed [COORD_WIDTH-1:0]       third_y,
	output logic                                done,
	output logic signed [COORD_WIDTH-1:0]       center_x,
	output logic signed [COORD_WIDTH-1:0]       center_y,
	output logic [COORD_WIDTH-1:0]              circle_radius,
	output logic                                points_collinear,
	output logic                                result_saturated
);
	import ccfp_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int CW  = W + 3;
	localparam int NAW = ccfp_num_w(W);
	localparam int DW  = ccfp_den_w(W);
	localparam int RW  = 2 * W + 4;
	localparam int SQW = 2 * CW;
	localparam int SBQ = 2 * W + 2;
	localparam logic REG_THRESHOLD = 1'b0;

	logic [CCFP_THR_WIDTH-1:0] thr_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? thr_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= CCFP_THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			thr_q <= pwdata;
		end
	end

	logic                 fv;
	ccfp_ctl_t            fctl;
	logic signed [W-1:0]  fx1, fy1;
	logic [NAW-1:0]       fnx, fny;
	logic [DW-1:0]        fden;

	ccfp_front #(.COORD_WIDTH(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.third_x   (third_x),
		.third_y   (third_y),
		.threshold (thr_q),
		.out_valid (fv),
		.out_ctl   (fctl),
		.out_x1    (fx1),
		.out_y1    (fy1),
		.out_numx  (fnx),
		.out_numy  (fny),
		.out_den   (fden)
	);

	logic                 dvx, dvy;
	logic signed [CW-1:0] qx, qy;
	logic [W:0]           sbx;
	logic [W-1:0]         sby;

	ccfp_rdiv #(.COORD_WIDTH(W), .SB_W(W + 1)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fv),
		.in_num    (fnx),
		.in_den    (fden),
		.in_neg    (fctl.negx),
		.in_ovf    (fctl.ovfx),
		.in_sb     ({fctl.collinear, fx1}),
		.out_valid (dvx),
		.out_quot  (qx),
		.out_sb    (sbx)
	);

	ccfp_rdiv #(.COORD_WIDTH(W), .SB_W(W)) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fv),
		.in_num    (fny),
		.in_den    (fden),
		.in_neg    (fctl.negy),
		.in_ovf    (fctl.ovfy),
		.in_sb     (fy1),
		.out_valid (dvy),
		.out_quot  (qy),
		.out_sb    (sby)
	);

	// back end: offsets, squares, sum
	logic                 v_s1, v_s2, v_s3;
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic [W-1:0]         cx_s1, cy_s1, cx_s2, cy_s2, cx_s3, cy_s3;
	logic                 sat_s1, sat_s2, sat_s3;
	logic                 col_s1, col_s2, col_s3;
	logic [RW-1:0]        sqx_s2, sqy_s2, r2_s3;

	logic                 inx, iny;
	logic signed [SQW-1:0] psx, psy;

	always_comb begin
		inx = (&qx[CW-1:W-1]) || !(|qx[CW-1:W-1]);
		iny = (&qy[CW-1:W-1]) || !(|qy[CW-1:W-1]);
		psx = dx_s1 * dx_s1;
		psy = dy_s1 * dy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= dvx && dvy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= CW'($signed(sbx[W-1:0])) - qx;
		dy_s1  <= CW'($signed(sby)) - qy;
		cx_s1  <= inx ? qx[W-1:0] : {qx[CW-1], {(W-1){!qx[CW-1]}}};
		cy_s1  <= iny ? qy[W-1:0] : {qy[CW-1], {(W-1){!qy[CW-1]}}};
		sat_s1 <= !inx || !iny;
		col_s1 <= sbx[W];
		sqx_s2 <= psx[RW-1:0];
		sqy_s2 <= psy[RW-1:0];
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		sat_s2 <= sat_s1;
		col_s2 <= col_s1;
		r2_s3  <= sqx_s2 + sqy_s2;
		cx_s3  <= cx_s2;
		cy_s3  <= cy_s2;
		sat_s3 <= sat_s2;
		col_s3 <= col_s2;
	end

	logic           rv;
	logic [W+1:0]   root;
	logic [SBQ-1:0] rsb;

	ccfp_isqrt #(.COORD_WIDTH(W), .SB_W(SBQ)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_rad    (r2_s3),
		.in_sb     ({col_s3, sat_s3, cx_s3, cy_s3}),
		.out_valid (rv),
		.out_root  (root),
		.out_sb    (rsb)
	);

	logic         rcol, rsat, rbig;
	logic [W-1:0] rcx, rcy;

	always_comb begin
		{rcol, rsat, rcx, rcy} = rsb;
		rbig = |root[W+1:W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= rv;
		end
	end

	always_ff @(posedge clk) begin
		points_collinear <= rcol;
		center_x         <= rcol ? '0 : rcx;
		center_y         <= rcol ? '0 : rcy;
		circle_radius    <= rcol ? '0 : (rbig ? '1 : root[W-1:0]);
		result_saturated <= !rcol && (rsat || rbig);
	end

endmodule

// ----- src/ccfp_checker.sv -----
`include "assert_macros.svh"

module ccfp_checker #(
	parameter int COORD_WIDTH = ccfp_pkg::CCFP_COORD_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [COORD_WIDTH-1:0] center_x,
	input logic [COORD_WIDTH-1:0] center_y,
	input logic [COORD_WIDTH-1:0] circle_radius,
	input logic                   points_collinear,
	input logic                   result_saturated
);
	import ccfp_pkg::*;

	localparam int LAT = ccfp_latency(COORD_WIDTH);

	`CCFP_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`CCFP_ASSERT_IMP(a_collinear_zero, clk, arst_n, done && points_collinear, center_x == '0 && center_y == '0 && circle_radius == '0 && !result_saturated)
	`CCFP_ASSERT_DLY(a_start_done, clk, arst_n, start && !busy, LAT, done)
	`CCFP_ASSERT_IMP(a_done_start, clk, arst_n, done, $past(start && !busy, LAT))

endmodule

bind circumcircle_from_three_points_core ccfp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ccfp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.center_x         (center_x),
	.center_y         (center_y),
	.circle_radius    (circle_radius),
	.points_collinear (points_collinear),
	.result_saturated (result_saturated)
);
